// ----- hw/rtl/sme_pkg.sv -----
`default_nettype none
package sme_pkg;

    localparam int MaxSamplesDef = 128;
    localparam int SampleBitsDef = 16;
    localparam int FracBitsDef   = 8;
    localparam int SkewFrac      = 10;
    localparam int AccBits       = 64;

    // status codes
    localparam logic [1:0] StOk       = 2'd0;
    localparam logic [1:0] StFew      = 2'd1;
    localparam logic [1:0] StZeroVar  = 2'd2;
    localparam logic [1:0] StOverflow = 2'd3;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
    } t_in_word;

    typedef struct packed {
        logic        [7:0]  set_size;
        logic signed [15:0] sample_mean;
        logic        [24:0] sample_variance;
        logic signed [15:0] sample_skew;
        logic        [1:0]  status;
    } t_out_word;

endpackage
`default_nettype wire

// ----- hw/rtl/sme_front.sv -----
`default_nettype none
module sme_front #(
    parameter int MAX_SAMPLES = 128,
    parameter int SAMPLE_BITS = 16,
    parameter int CNT_BITS    = 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    input  wire                          i_stall_q,
    input  wire signed [SAMPLE_BITS-1:0] i_sample,
    input  wire                          i_last,
    output logic                         o_stall,
    output logic                         o_wr_en,
    output logic [CNT_BITS-1:0]          o_wr_addr,
    output logic signed [SAMPLE_BITS-1:0] o_wr_data,
    output logic                         o_close,
    output logic [CNT_BITS-1:0]          o_close_n,
    output logic                         o_close_ovf
);
    import sme_pkg::*;

    logic [CNT_BITS-1:0] r_count, n_count;
    logic                r_ovf, n_ovf;
    logic                acc, full;
    logic [CNT_BITS-1:0] cnt_inc;

    // accept only when the back part has room for a closed set
    assign o_stall   = i_stall_q;
    assign acc       = i_valid && !i_stall_q;
    assign full      = (r_count == CNT_BITS'(MAX_SAMPLES));
    assign cnt_inc   = r_count + CNT_BITS'(1);
    assign o_wr_en   = acc && !full;
    assign o_wr_addr = r_count;
    assign o_wr_data = i_sample;
    assign o_close   = acc && i_last;
    assign o_close_n = full ? r_count : cnt_inc;
    assign o_close_ovf = r_ovf || full;

    // set bookkeeping
    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (acc) begin
            if (full) n_ovf = 1'b1;
            else      n_count = cnt_inc;
            if (i_last) begin
                n_count = '0;
                n_ovf   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/sme_back.sv -----
`default_nettype none
module sme_back #(
    parameter int MAX_SAMPLES = 128,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8,
    parameter int CNT_BITS    = 8
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_wr_en,
    input  wire [CNT_BITS-1:0]            i_wr_addr,
    input  wire signed [SAMPLE_BITS-1:0]  i_wr_data,
    input  wire                           i_close,
    input  wire [CNT_BITS-1:0]            i_close_n,
    input  wire                           i_close_ovf,
    output logic                          o_busy,
    output logic                          o_valid,
    input  wire                           i_stall,
    output sme_pkg::t_out_word            o_word
);
    import sme_pkg::*;

    localparam int AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int A    = AccBits;
    // deviation, its square and cube, variance, root and denominator widths
    localparam int DW   = SAMPLE_BITS + 2;
    localparam int D2W  = 2 * DW;
    localparam int D3W  = 3 * DW;
    localparam int VW   = D2W;
    localparam int RW   = DW;
    localparam int DENW = VW + CNT_BITS;
    localparam int PW   = DENW + RW;

    typedef enum logic [3:0] {
        S_IDLE, S_SUM, S_MEAN, S_DEV, S_MUL2, S_MUL3, S_VDIV, S_ROOT,
        S_DEN1, S_DEN2, S_SDIV, S_FRAC, S_OUT
    } t_state;

    logic signed [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
    logic signed [SAMPLE_BITS-1:0] r_rd;
    logic [AW-1:0]                 rd_addr;

    t_state              r_st;
    logic [CNT_BITS-1:0] r_n, r_idx;
    logic                r_ovf, r_rdv;
    logic [A-1:0]        r_sum, r_m, r_sq, r_cube;
    logic signed [DW-1:0] r_d;
    logic [D2W-1:0]      r_d2;
    logic [A-1:0]        r_v, r_r, r_den, r_mag;
    logic                r_neg;
    // shared restoring divider / root
    logic [A-1:0]        r_q, r_rem, r_num, r_dv, r_bit;
    logic [6:0]          r_k;
    logic [3:0]          r_fk;
    t_out_word           r_out;
    logic                r_ovalid;
    logic                r_mneg;

    logic [A-1:0] rem_sh;
    logic signed [A-1:0] s_m;
    logic signed [D3W-1:0] cube_p;

    // sample store
    assign rd_addr = r_idx[AW-1:0];
    always_ff @(posedge i_clk) begin
        if (i_wr_en) mem[i_wr_addr[AW-1:0]] <= i_wr_data;
        r_rd <= mem[rd_addr];
    end

    assign o_busy  = (r_st != S_IDLE) || r_ovalid;
    assign o_valid = r_ovalid;
    assign o_word  = r_out;
    assign rem_sh  = {r_rem[A-2:0], r_num[A-1]};
    assign s_m     = $signed(r_m);
    // cube of one deviation, square already registered
    assign cube_p  = D3W'($signed({1'b0, r_d2})) * D3W'(r_d);

    // one iterative sequencer: sum pass, mean divide, deviation pass, variance divide, root, skew divide
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: begin
                    if (i_close) begin
                        r_n   <= i_close_n;
                        r_ovf <= i_close_ovf;
                        r_idx <= '0;
                        r_rdv <= 1'b0;
                        r_sum <= '0;
                        r_st  <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_rdv <= (r_idx < r_n);
                    if (r_rdv) r_sum <= r_sum + A'($signed(r_rd));
                    if (r_idx < r_n) r_idx <= r_idx + CNT_BITS'(1);
                    else if (!r_rdv) begin
                        r_mneg <= r_sum[A-1];
                        r_num  <= r_sum[A-1] ? (A'(0) - r_sum) : r_sum;
                        r_dv   <= A'(r_n);
                        r_rem  <= '0;
                        r_k    <= 7'd0;
                        r_st   <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    if (r_n == '0) begin
                        r_m <= '0;
                        r_st <= S_OUT;
                    end else if (r_k == 7'(A)) begin
                        r_m   <= r_mneg ? (A'(0) - r_num) : r_num;
                        r_idx <= '0;
                        r_rdv <= 1'b0;
                        r_sq  <= '0;
                        r_cube <= '0;
                        r_st  <= S_DEV;
                    end else begin
                        r_k <= r_k + 7'd1;
                        if (rem_sh >= r_dv) begin
                            r_rem <= rem_sh - r_dv;
                            r_num <= {r_num[A-2:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh;
                            r_num <= {r_num[A-2:0], 1'b0};
                        end
                    end
                end
                S_DEV: begin
                    if (r_rdv) begin
                        r_d  <= DW'(A'($signed(r_rd)) - r_m);
                        r_rdv <= 1'b0;
                        r_st <= S_MUL2;
                    end else if (r_idx < r_n) begin
                        r_idx <= r_idx + CNT_BITS'(1);
                        r_rdv <= 1'b1;
                    end else if (r_n < CNT_BITS'(2)) begin
                        r_st <= S_OUT;
                    end else begin
                        r_num <= r_sq;
                        r_dv  <= A'(r_n - CNT_BITS'(1));
                        r_rem <= '0;
                        r_k   <= 7'd0;
                        r_st  <= S_VDIV;
                    end
                end
                S_MUL2: begin
                    r_d2 <= D2W'(r_d) * D2W'(r_d);
                    r_st <= S_MUL3;
                end
                S_MUL3: begin
                    r_sq   <= r_sq + A'(r_d2);
                    r_cube <= r_cube + A'(cube_p);
                    r_st   <= S_DEV;
                end
                S_VDIV: begin
                    if (r_k == 7'(A)) begin
                        r_v   <= r_num;
                        r_rem <= r_num;
                        r_q   <= '0;
                        r_bit <= A'(1) << (A - 2);
                        r_st  <= (r_num == '0) ? S_OUT : S_ROOT;
                    end else begin
                        r_k <= r_k + 7'd1;
                        if (rem_sh >= r_dv) begin
                            r_rem <= rem_sh - r_dv;
                            r_num <= {r_num[A-2:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh;
                            r_num <= {r_num[A-2:0], 1'b0};
                        end
                    end
                end
                S_ROOT: begin
                    // r_rem holds remaining value, r_q result
                    if (r_bit == '0) begin
                        r_r  <= r_q;
                        r_st <= S_DEN1;
                    end else begin
                        if (r_rem >= r_q + r_bit) begin
                            r_rem <= r_rem - (r_q + r_bit);
                            r_q   <= (r_q >> 1) + r_bit;
                        end else begin
                            r_q <= r_q >> 1;
                        end
                        r_bit <= r_bit >> 2;
                    end
                end
                S_DEN1: begin
                    r_den <= A'(DENW'(r_v[VW-1:0]) * DENW'(r_n - CNT_BITS'(1)));
                    r_st  <= S_DEN2;
                end
                S_DEN2: begin
                    r_den <= A'(PW'(r_den[DENW-1:0]) * PW'(r_r[RW-1:0]));
                    r_neg <= r_cube[A-1];
                    r_st  <= S_SDIV;
                    r_rem <= '0;
                    r_k   <= 7'd0;
                    r_num <= r_cube[A-1] ? (A'(0) - r_cube) : r_cube;
                end
                S_SDIV: begin
                    if (r_den == '0) r_den <= A'(1);
                    else if (r_k == 7'(A)) begin
                        r_mag <= (r_num >= (A'(1) << 40)) ? (A'(1) << 40) : r_num;
                        r_fk  <= 4'd0;
                        r_st  <= S_FRAC;
                    end else begin
                        r_k <= r_k + 7'd1;
                        if (rem_sh >= r_den) begin
                            r_rem <= rem_sh - r_den;
                            r_num <= {r_num[A-2:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh;
                            r_num <= {r_num[A-2:0], 1'b0};
                        end
                    end
                end
                S_FRAC: begin
                    if (r_fk == 4'(SkewFrac)) begin
                        r_st <= S_OUT;
                    end else begin
                        r_fk <= r_fk + 4'd1;
                        if (r_rem >= r_den - r_rem) begin
                            r_rem <= r_rem - (r_den - r_rem);
                            r_mag <= {r_mag[A-2:0], 1'b1};
                        end else begin
                            r_rem <= r_rem << 1;
                            r_mag <= {r_mag[A-2:0], 1'b0};
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_out.set_size <= 8'(r_n);
                        r_out.sample_mean <= (s_m > 64'sd32767) ? 16'sd32767 :
                            (s_m < -64'sd32768) ? -16'sd32768 : 16'(r_m);
                        r_out.sample_variance <= '0;
                        r_out.sample_skew <= '0;
                        if (r_n < CNT_BITS'(2)) begin
                            r_out.status <= StFew;
                        end else if (r_v == '0) begin
                            r_out.status <= r_ovf ? StOverflow : StZeroVar;
                        end else begin
                            r_out.status <= r_ovf ? StOverflow : StOk;
                            r_out.sample_variance <=
                                ((r_v >> FRAC_BITS) > A'(32'd16777216)) ?
                                25'd16777216 : 25'(r_v >> FRAC_BITS);
                            if (r_mag > A'(32767))
                                r_out.sample_skew <= r_neg ? -16'sd32768 : 16'sd32767;
                            else
                                r_out.sample_skew <= r_neg ? -$signed(16'(r_mag))
                                                           : $signed(16'(r_mag));
                        end
                        r_ovalid <= 1'b1;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
            if (r_st == S_IDLE && !i_close) begin
                r_v <= '0;
            end
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/sample_moments_engine.sv -----
`default_nettype none
// Sample moments engine: takes signed Q8.8 sample words, one per accepted
// input word; the word marked last closes the set and yields one result word
// (count, mean, variance, skewness, status). Samples are written to the store
// as they are accepted; after the last one the back end walks the store twice
// and runs 64-bit restoring divides and a square root, one bit or step per
// cycle. Input stalls while a closed set is being worked or its result waits
// to be taken.
module sample_moments_engine #(
    parameter int MAX_SAMPLES = sme_pkg::MaxSamplesDef,
    parameter int FRAC_BITS   = sme_pkg::FracBitsDef
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  sme_pkg::t_in_word   i_word,
    output logic                o_valid,
    input  wire                 i_stall,
    output sme_pkg::t_out_word  o_word
);
    import sme_pkg::*;

    localparam int SB = SampleBitsDef;
    localparam int CB = $clog2(MAX_SAMPLES + 1);

    logic                 busy, wr_en, close, close_ovf;
    logic [CB-1:0]        wr_addr, close_n;
    logic signed [SB-1:0] wr_data;

    sme_front #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SB), .CNT_BITS(CB)) u_front (
        .i_clk, .i_rst_n, .i_valid, .i_stall_q(busy),
        .i_sample(i_word.sample), .i_last(i_word.last), .o_stall,
        .o_wr_en(wr_en), .o_wr_addr(wr_addr), .o_wr_data(wr_data),
        .o_close(close), .o_close_n(close_n), .o_close_ovf(close_ovf)
    );

    sme_back #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SB),
               .FRAC_BITS(FRAC_BITS), .CNT_BITS(CB)) u_back (
        .i_clk, .i_rst_n, .i_wr_en(wr_en), .i_wr_addr(wr_addr),
        .i_wr_data(wr_data), .i_close(close), .i_close_n(close_n),
        .i_close_ovf(close_ovf), .o_busy(busy), .o_valid, .i_stall, .o_word
    );
endmodule
`default_nettype wire
